// ===== rtl/rc_link_frame_parser_assert.svh =====
// ----------------------------------------------------------------------------
// rc_link_frame_parser_assert.svh
// Assertion macros used by the frame parser decoder.
// ----------------------------------------------------------------------------
`ifndef RC_LINK_FRAME_PARSER_ASSERT_SVH
`define RC_LINK_FRAME_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is high
`define RCLFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds through reset
`define RCLFP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCLFP_ASSERT(label, clk, rst, prop, msg)
`define RCLFP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/rclfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rclfp_pkg
// Constants, types and the CRC-8 step shared by the frame parser.
// ----------------------------------------------------------------------------
package rclfp_pkg;

   // frame format
   localparam logic [7:0] ADDR_RESET     = 8'hC8;
   localparam logic [7:0] TYPE_CHANNELS  = 8'h16;
   localparam logic [7:0] TYPE_LINKSTATS = 8'h14;
   localparam logic [7:0] LEN_MIN        = 8'd2;
   localparam logic [7:0] LEN_MAX        = 8'd62;
   localparam logic [7:0] CRC_POLY       = 8'hD5;

   // decoding
   localparam logic [5:0]  CHAN_MIN_LEN  = 6'd24;
   localparam logic [5:0]  STATS_MAX     = 6'd10;
   localparam logic [5:0]  STATS_SKIP    = 6'd2;
   localparam logic [3:0]  LAST_CHANNEL  = 4'd15;
   localparam logic [4:0]  CHAN_BITS     = 5'd11;
   localparam logic [4:0]  BYTE_BITS     = 5'd8;
   localparam logic [10:0] CHAN_MASK     = 11'h7FF;

   // result kinds
   localparam logic KIND_CHANNEL = 1'b0;
   localparam logic KIND_STAT    = 1'b1;

   // handoff from receiver to decoder on a good frame
   typedef struct packed {
      logic       go;
      logic [5:0] length;
   } start_type;

   // one byte of CRC-8, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/rclfp_req_if.sv =====
// ----------------------------------------------------------------------------
// rclfp_req_if
// Received byte channel: valid, ready and one byte per item.
// ----------------------------------------------------------------------------
interface rclfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/rclfp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rclfp_rsp_if
// Result channel: valid, ready and one decoded value per item.
// ----------------------------------------------------------------------------
interface rclfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [3:0]  item_index;
   logic [10:0] item_value;
   logic        last_of_frame;

   modport source (output valid, output result_kind, output item_index,
                   output item_value, output last_of_frame, input ready);
   modport sink   (input valid, input result_kind, input item_index,
                   input item_value, input last_of_frame, output ready);
endinterface

// ===== rtl/rc_link_frame_parser.sv =====
// ----------------------------------------------------------------------------
// rc_link_frame_parser
// Remote-control link frame receiver with CRC-8 check and channel unpacking.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                       handshake
//  req_chan  in         rx_byte[7:0]                                  valid/ready
//  rsp_chan  out        result_kind, item_index[3:0], item_value[10:0],
//                       last_of_frame                                 valid/ready
//  csr_*     in         frame_address[7:0] write                      write enable
//
//  A received byte is taken while the decoder is idle; the byte that closes
//  a good frame starts the decoder, and req_chan.ready stays low until its
//  run is done. The run is bound by the one read port of the frame store.
//  Result stalls hold the decoder in place; the output register keeps one item.
//  Reset (synchronous) returns to address hunt with frame_address = 0xC8;
//  the frame store is not cleared, every read byte is written by the frame.
// ----------------------------------------------------------------------------
module rc_link_frame_parser #(
   parameter int FRAME_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   rclfp_req_if.sink   req_chan,
   rclfp_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(FRAME_BYTES);

   logic [7:0]           frame_address_ff;
   logic                 accept;
   logic                 dec_idle;
   rclfp_pkg::start_type start;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [7:0]           wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [7:0]           rd_data;

   // address register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_address_ff <= rclfp_pkg::ADDR_RESET;
      end else if (csr_write_enable) begin
         frame_address_ff <= csr_write_data;
      end
   end

   // bytes are held off while the store is being read back
   assign req_chan.ready = dec_idle;
   assign accept         = req_chan.valid && dec_idle;

   rclfp_rx #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_rx (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_chan.rx_byte),
      .frame_address (frame_address_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .start         (start)
   );

   rclfp_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rclfp_decoder #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_decoder (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .idle    (dec_idle),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp     (rsp_chan)
   );

endmodule

// ===== rtl/rclfp_ram.sv =====
// ----------------------------------------------------------------------------
// rclfp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rclfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rclfp_rx.sv =====
// ----------------------------------------------------------------------------
// rclfp_rx
// Byte receiver: address hunt, length check, body store and CRC-8.
// ----------------------------------------------------------------------------
module rclfp_rx #(
   parameter int FRAME_BYTES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     rx_byte,
   input  logic [7:0]                     frame_address,
   output logic                           wr_en,
   output logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output rclfp_pkg::start_type           start
);

   localparam int AW = $clog2(FRAME_BYTES);

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_LEN  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [5:0] length_ff, length_in;
   logic [5:0] taken_ff, taken_in;
   logic [7:0] crc_ff, crc_in;

   logic       final_byte;
   logic       in_store;

   assign final_byte = ({1'b0, taken_ff} + 7'd1) >= {1'b0, length_ff};
   assign in_store   = {1'b0, taken_ff} < 7'(FRAME_BYTES);

   // next state per accepted byte
   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      taken_in     = taken_ff;
      crc_in       = crc_ff;
      wr_en        = 1'b0;
      start.go     = 1'b0;
      start.length = length_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (rx_byte >= rclfp_pkg::LEN_MIN && rx_byte <= rclfp_pkg::LEN_MAX) begin
                  length_in = rx_byte[5:0];
                  taken_in  = '0;
                  crc_in    = '0;
                  phase_in  = PH_BODY;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               if (final_byte) begin
                  // CRC byte: hand a good frame to the decoder
                  start.go = (rx_byte == crc_ff);
                  phase_in = PH_HUNT;
                  taken_in = '0;
               end else begin
                  wr_en    = in_store;
                  crc_in   = rclfp_pkg::crc8_update(crc_ff, rx_byte);
                  taken_in = taken_ff + 6'd1;
               end
            end
            default: begin
               phase_in = (rx_byte == frame_address) ? PH_LEN : PH_HUNT;
            end
         endcase
      end
   end

   assign wr_addr = taken_ff[AW-1:0];
   assign wr_data = rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= '0;
         taken_ff  <= '0;
         crc_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         taken_ff  <= taken_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

// ===== rtl/rclfp_decoder.sv =====
// ----------------------------------------------------------------------------
// rclfp_decoder
// Reads a stored frame back one byte at a time and emits its results.
// ----------------------------------------------------------------------------
`include "rc_link_frame_parser_assert.svh"

module rclfp_decoder #(
   parameter int FRAME_BYTES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rclfp_pkg::start_type           start,
   output logic                           idle,
   output logic                           rd_en,
   output logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
   input  logic [7:0]                     rd_data,
   rclfp_rsp_if.source                    rsp
);

   localparam int AW = $clog2(FRAME_BYTES);

   typedef enum logic [3:0] {
      DEC_IDLE  = 4'b0001,
      DEC_ISSUE = 4'b0010,
      DEC_DATA  = 4'b0100,
      DEC_EMIT  = 4'b1000
   } dec_state_type;

   typedef enum logic [2:0] {
      MODE_TYPE = 3'b001,
      MODE_CHAN = 3'b010,
      MODE_STAT = 3'b100
   } mode_type;

   dec_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [5:0]    length_ff, length_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [17:0]   acc_ff, acc_in;
   logic [4:0]    nbits_ff, nbits_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [3:0]    last_idx_ff, last_idx_in;

   logic          out_valid_ff;
   logic          out_kind_ff;
   logic [3:0]    out_index_ff;
   logic [10:0]   out_value_ff;
   logic          out_last_ff;

   logic          slot_free;
   logic          emit_load;
   logic [5:0]    stat_avail;
   logic [5:0]    stat_cnt;
   logic [10:0]   emit_value;

   assign slot_free  = !out_valid_ff || rsp.ready;
   assign stat_avail = length_ff - rclfp_pkg::STATS_SKIP;
   assign stat_cnt   = (stat_avail > rclfp_pkg::STATS_MAX) ? rclfp_pkg::STATS_MAX : stat_avail;
   assign emit_value = (mode_ff == MODE_STAT) ? {3'b000, acc_ff[7:0]}
                                              : (acc_ff[10:0] & rclfp_pkg::CHAN_MASK);

   // read, unpack and emit sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      length_in   = length_ff;
      ptr_in      = ptr_ff;
      acc_in      = acc_ff;
      nbits_in    = nbits_ff;
      cnt_in      = cnt_ff;
      last_idx_in = last_idx_ff;
      rd_en       = 1'b0;
      emit_load   = 1'b0;
      unique case (state_ff)
         DEC_IDLE: begin
            if (start.go) begin
               length_in = start.length;
               mode_in   = MODE_TYPE;
               ptr_in    = '0;
               state_in  = DEC_ISSUE;
            end
         end
         DEC_ISSUE: begin
            rd_en    = 1'b1;
            state_in = DEC_DATA;
         end
         DEC_DATA: begin
            unique case (mode_ff)
               MODE_CHAN: begin
                  // append the byte above the bits still pending
                  acc_in   = acc_ff | (18'(rd_data) << nbits_ff);
                  nbits_in = nbits_ff + rclfp_pkg::BYTE_BITS;
                  if ((nbits_ff + rclfp_pkg::BYTE_BITS) >= rclfp_pkg::CHAN_BITS) begin
                     state_in = DEC_EMIT;
                  end else begin
                     ptr_in   = ptr_ff + AW'(1);
                     state_in = DEC_ISSUE;
                  end
               end
               MODE_STAT: begin
                  acc_in   = 18'(rd_data);
                  state_in = DEC_EMIT;
               end
               default: begin
                  // type byte picks the run, if any
                  acc_in   = '0;
                  nbits_in = '0;
                  cnt_in   = '0;
                  ptr_in   = AW'(1);
                  if (rd_data == rclfp_pkg::TYPE_CHANNELS &&
                      length_ff >= rclfp_pkg::CHAN_MIN_LEN) begin
                     mode_in     = MODE_CHAN;
                     last_idx_in = rclfp_pkg::LAST_CHANNEL;
                     state_in    = DEC_ISSUE;
                  end else if (rd_data == rclfp_pkg::TYPE_LINKSTATS &&
                               length_ff > rclfp_pkg::STATS_SKIP) begin
                     mode_in     = MODE_STAT;
                     last_idx_in = 4'(stat_cnt - 6'd1);
                     state_in    = DEC_ISSUE;
                  end else begin
                     state_in = DEC_IDLE;
                  end
               end
            endcase
         end
         DEC_EMIT: begin
            if (slot_free) begin
               emit_load = 1'b1;
               acc_in    = acc_ff >> rclfp_pkg::CHAN_BITS;
               nbits_in  = nbits_ff - rclfp_pkg::CHAN_BITS;
               cnt_in    = cnt_ff + 4'd1;
               if (cnt_ff == last_idx_ff) begin
                  state_in = DEC_IDLE;
               end else begin
                  ptr_in   = ptr_ff + AW'(1);
                  state_in = DEC_ISSUE;
               end
            end
         end
         default: begin
            state_in = DEC_IDLE;
         end
      endcase
   end

   assign idle    = (state_ff == DEC_IDLE);
   assign rd_addr = ptr_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DEC_IDLE;
         mode_ff      <= MODE_TYPE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         if (emit_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath and output register
   always_ff @(posedge clock) begin
      length_ff   <= length_in;
      ptr_ff      <= ptr_in;
      acc_ff      <= acc_in;
      nbits_ff    <= nbits_in;
      cnt_ff      <= cnt_in;
      last_idx_ff <= last_idx_in;
      if (emit_load) begin
         out_kind_ff  <= (mode_ff == MODE_STAT) ? rclfp_pkg::KIND_STAT
                                                : rclfp_pkg::KIND_CHANNEL;
         out_index_ff <= cnt_ff;
         out_value_ff <= emit_value;
         out_last_ff  <= (cnt_ff == last_idx_ff);
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.result_kind   = out_kind_ff;
   assign rsp.item_index    = out_index_ff;
   assign rsp.item_value    = out_value_ff;
   assign rsp.last_of_frame = out_last_ff;

   // checks
   `RCLFP_ASSERT(a_start_when_idle, clock, reset, start.go |-> state_ff == DEC_IDLE, "frame start while decoding")
   `RCLFP_ASSERT(a_last_ends_run, clock, reset, (emit_load && cnt_ff == last_idx_ff) |=> state_ff == DEC_IDLE, "run did not end on last item")
   `RCLFP_ASSERT(a_index_bound, clock, reset, emit_load |-> cnt_ff <= last_idx_ff, "item index beyond run")
   `RCLFP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == DEC_IDLE && !out_valid_ff), "decoder not idle after reset")

endmodule
